[design/qte_pkg.sv]
// shared types, constants and the arctangent table for the quaternion to euler converter
// no dependencies; used by qte_atan and quaternion_to_euler_angles_top
package qte_pkg;

    localparam int MAG_W    = 33;   // magnitude of any atan2 argument
    localparam int ANG_W    = 26;   // signed angle accumulator, 2^-16 degree
    localparam int ZOUT_W   = 23;   // first-quadrant angle, 0..90 degrees
    localparam int ROOT_W   = 31;
    localparam int RAD_W    = 62;
    localparam int TAB_LEN  = 24;

    localparam logic [ZOUT_W-1:0] DEG90  = 23'd5898240;
    localparam logic [ZOUT_W:0]   DEG180 = 24'd11796480;
    localparam logic [15:0]       ROLL_LIMIT  = 16'd23040;
    localparam logic [15:0]       PITCH_LIMIT = 16'd11520;

    typedef struct packed {
        logic [MAG_W-1:0]  rs_mag;
        logic              rs_neg;
        logic [MAG_W-1:0]  rc_mag;
        logic              rc_neg;
        logic [MAG_W-1:0]  ys_mag;
        logic              ys_neg;
        logic [MAG_W-1:0]  yc_mag;
        logic              yc_neg;
        logic [ROOT_W-1:0] pm;
        logic              p_neg;
        logic              p_clamp;
        logic              invalid;
    } meta_t;

    typedef struct packed {
        logic rs_neg;
        logic rc_neg;
        logic ys_neg;
        logic yc_neg;
        logic p_neg;
        logic p_clamp;
        logic invalid;
    } flags_t;

    // atan(2^-i) in 2^-16 degree, rounded to nearest
    function automatic logic [21:0] atan_tab(input int unsigned i);
        logic [21:0] v;
        unique case (i)
            0:  v = 22'd2949120;
            1:  v = 22'd1740967;
            2:  v = 22'd919879;
            3:  v = 22'd466945;
            4:  v = 22'd234379;
            5:  v = 22'd117304;
            6:  v = 22'd58666;
            7:  v = 22'd29335;
            8:  v = 22'd14668;
            9:  v = 22'd7334;
            10: v = 22'd3667;
            11: v = 22'd1833;
            12: v = 22'd917;
            13: v = 22'd458;
            14: v = 22'd229;
            15: v = 22'd115;
            16: v = 22'd57;
            17: v = 22'd29;
            18: v = 22'd14;
            19: v = 22'd7;
            20: v = 22'd4;
            21: v = 22'd2;
            22: v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

endpackage

[design/qte_atan.sv]
// pipelined first-quadrant atan2 by vectoring cordic: leading-one, scale, iteration and output registers
// depends on qte_pkg
module qte_atan #(
    parameter int ITER = 16
) (
    input  logic                        aclk,
    input  logic                        en,
    input  logic [qte_pkg::MAG_W-1:0]   ay,
    input  logic [qte_pkg::MAG_W-1:0]   ax,
    output logic [qte_pkg::ZOUT_W-1:0]  angle
);

    localparam int NI = (ITER < qte_pkg::TAB_LEN) ? ITER : qte_pkg::TAB_LEN;
    localparam int MW = qte_pkg::MAG_W;
    localparam int AW = qte_pkg::ANG_W;

    // stage a: leading one of the larger argument
    logic [MW-1:0] a_ax_reg, a_ay_reg;
    logic [5:0]    a_pos_reg;
    logic          a_zy_reg, a_zx_reg;
    logic [MW-1:0] m_max;
    logic [5:0]    pos_next;

    assign m_max = (ax > ay) ? ax : ay;

    always_comb begin
        pos_next = '0;
        for (int b = 0; b < MW; b++) begin
            if (m_max[b]) pos_next = 6'(b);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_ax_reg  <= ax;
            a_ay_reg  <= ay;
            a_pos_reg <= pos_next;
            a_zy_reg  <= (ay == '0);
            a_zx_reg  <= (ax == '0);
        end
    end

    // stage b: scale so the larger one lies in [2^29, 2^30)
    logic signed [MW:0]   x_reg [0:NI];
    logic signed [MW:0]   y_reg [0:NI];
    logic signed [AW-1:0] z_reg [0:NI];
    logic [1:0]           sp_reg [0:NI];
    logic [MW-1:0]        x_sh, y_sh;

    always_comb begin
        if (a_pos_reg >= 6'd29) begin
            x_sh = a_ax_reg >> (a_pos_reg - 6'd29);
            y_sh = a_ay_reg >> (a_pos_reg - 6'd29);
        end else begin
            x_sh = a_ax_reg << (6'd29 - a_pos_reg);
            y_sh = a_ay_reg << (6'd29 - a_pos_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0]  <= $signed({1'b0, x_sh});
            y_reg[0]  <= $signed({1'b0, y_sh});
            z_reg[0]  <= '0;
            sp_reg[0] <= {a_zy_reg, a_zx_reg};
        end
    end

    for (genvar k = 0; k < NI; k++) begin : g_iter
        logic signed [MW:0]   xs, ys;
        logic signed [AW-1:0] t;
        assign xs = x_reg[k] >>> k;
        assign ys = y_reg[k] >>> k;
        assign t  = $signed(AW'(qte_pkg::atan_tab(k)));
        always_ff @(posedge aclk) begin
            if (en) begin
                if (!y_reg[k][MW]) begin
                    x_reg[k+1] <= x_reg[k] + ys;
                    y_reg[k+1] <= y_reg[k] - xs;
                    z_reg[k+1] <= z_reg[k] + t;
                end else begin
                    x_reg[k+1] <= x_reg[k] - ys;
                    y_reg[k+1] <= y_reg[k] + xs;
                    z_reg[k+1] <= z_reg[k] - t;
                end
                sp_reg[k+1] <= sp_reg[k];
            end
        end
    end

    // final: zero-argument cases and clamp to [0, 90] degrees
    logic [qte_pkg::ZOUT_W-1:0] angle_reg, angle_next;

    always_comb begin
        priority if (sp_reg[NI][1]) begin
            angle_next = '0;
        end else if (sp_reg[NI][0]) begin
            angle_next = qte_pkg::DEG90;
        end else if (z_reg[NI] < 0) begin
            angle_next = '0;
        end else if (z_reg[NI] > $signed(AW'(qte_pkg::DEG90))) begin
            angle_next = qte_pkg::DEG90;
        end else begin
            angle_next = qte_pkg::ZOUT_W'(z_reg[NI]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) angle_reg <= angle_next;
    end

    assign angle = angle_reg;

endmodule

[design/quaternion_to_euler_angles_top.sv]
// quaternion to euler angle converter: products, sums, pitch cosine by square root, three cordics
// depends on qte_pkg and qte_atan
//
// usage
//   s_ channel takes one quaternion request per cycle (s_tvalid and s_tready high).
//   m_ channel returns roll, pitch and yaw in 1/128 degree for each request, in order.
//   m_tuser flags a zero quaternion; the angles are then zero.
// pipeline
//   input register, products, atan2 arguments, sine clamp, cosine product, the 31 stage
//   square root of the pitch cosine, the cordic chain and the output register, in this order
// throughput
//   one request per cycle when no result is held; every stage is registered and moves together
// stall
//   when the result is held by m_tready low the whole pipeline freezes, s_tready drops,
//   nothing is lost or repeated; bubbles in the pipeline do not hold up the input
// reset
//   aresetn low (synchronous) empties the pipeline; data registers are not cleared
module quaternion_to_euler_angles_top #(
    parameter int CORDIC_ITERATIONS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // quat_w[15:0], quat_x[31:16], quat_y[47:32], quat_z[63:48]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // roll_deg[15:0], pitch_deg[30:16], yaw_deg[46:31], zero pad
    output logic        m_tuser    // invalid
);

    localparam int NI  = (CORDIC_ITERATIONS < qte_pkg::TAB_LEN) ?
                         CORDIC_ITERATIONS : qte_pkg::TAB_LEN;
    localparam int ATL = NI + 3;               // cordic latency
    localparam int SQN = qte_pkg::ROOT_W;      // square root stages
    localparam int LAT = 5 + SQN + ATL + 1;    // total stages
    localparam int MW  = qte_pkg::MAG_W;

    logic en;
    logic [LAT-1:0] valid_reg;

    // global advance: move when the output is empty or being taken
    assign en       = !valid_reg[LAT-1] || m_tready;
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[LAT-2:0], s_tvalid};
        end
    end

    // stage 1: input register
    logic signed [15:0] w_reg, x_reg, y_reg, z_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            w_reg <= s_tdata[15:0];
            x_reg <= s_tdata[31:16];
            y_reg <= s_tdata[47:32];
            z_reg <= s_tdata[63:48];
        end
    end

    // stage 2: all pairwise products
    logic signed [31:0] ww_reg, xx_reg, yy_reg, zz_reg;
    logic signed [31:0] wx_reg, yz_reg, wz_reg, xy_reg, wy_reg, zx_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            ww_reg <= w_reg * w_reg;
            xx_reg <= x_reg * x_reg;
            yy_reg <= y_reg * y_reg;
            zz_reg <= z_reg * z_reg;
            wx_reg <= w_reg * x_reg;
            yz_reg <= y_reg * z_reg;
            wz_reg <= w_reg * z_reg;
            xy_reg <= x_reg * y_reg;
            wy_reg <= w_reg * y_reg;
            zx_reg <= z_reg * x_reg;
        end
    end

    // stage 3: atan2 arguments as sign and magnitude, squared norm
    logic signed [34:0] n2_s, rs_s, rc_s, ys_s, yc_s, p_s;
    qte_pkg::meta_t     meta3_next, meta3_reg;
    logic [MW-1:0]      n2_reg, pm3_reg;

    function automatic logic [MW-1:0] mag35(input logic signed [34:0] v);
        logic signed [34:0] a;
        a = v[34] ? -v : v;
        return MW'(a);
    endfunction

    always_comb begin
        n2_s = 35'(ww_reg) + 35'(xx_reg) + 35'(yy_reg) + 35'(zz_reg);
        rs_s = (35'(wx_reg) + 35'(yz_reg)) <<< 1;
        rc_s = 35'(ww_reg) + 35'(zz_reg) - 35'(xx_reg) - 35'(yy_reg);
        ys_s = (35'(wz_reg) + 35'(xy_reg)) <<< 1;
        yc_s = 35'(ww_reg) + 35'(xx_reg) - 35'(yy_reg) - 35'(zz_reg);
        p_s  = (35'(wy_reg) - 35'(zx_reg)) <<< 1;
        meta3_next.rs_mag  = mag35(rs_s);
        meta3_next.rs_neg  = rs_s[34];
        meta3_next.rc_mag  = mag35(rc_s);
        meta3_next.rc_neg  = rc_s[34];
        meta3_next.ys_mag  = mag35(ys_s);
        meta3_next.ys_neg  = ys_s[34];
        meta3_next.yc_mag  = mag35(yc_s);
        meta3_next.yc_neg  = yc_s[34];
        meta3_next.pm      = '0;
        meta3_next.p_neg   = p_s[34];
        meta3_next.p_clamp = 1'b0;
        meta3_next.invalid = (n2_s == '0);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            meta3_reg <= meta3_next;
            n2_reg    <= MW'(n2_s);
            pm3_reg   <= mag35(p_s);
        end
    end

    // stage 4: pitch sine clamp, scale below 2^31, difference and sum for the cosine
    qte_pkg::meta_t meta4_next, meta4_reg;
    logic [30:0]    nsh, psh, a4_reg;
    logic [31:0]    b4_reg;
    logic           clamp4;

    always_comb begin
        clamp4 = (pm3_reg >= n2_reg);
        priority if (n2_reg[32]) begin
            nsh = 31'(n2_reg >> 2);
            psh = 31'(pm3_reg >> 2);
        end else if (n2_reg[31]) begin
            nsh = 31'(n2_reg >> 1);
            psh = 31'(pm3_reg >> 1);
        end else begin
            nsh = n2_reg[30:0];
            psh = pm3_reg[30:0];
        end
        if (clamp4) psh = '0;   // clamped sine: cosine path unused
        meta4_next         = meta3_reg;
        meta4_next.pm      = psh;
        meta4_next.p_clamp = clamp4;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            meta4_reg <= meta4_next;
            a4_reg    <= nsh - psh;
            b4_reg    <= 32'(nsh) + 32'(psh);
        end
    end

    // stage 5 and square root: cos^2 = (n-p)(n+p), then one root bit a stage
    logic [qte_pkg::RAD_W-1:0]  rem_reg  [0:SQN];
    logic [qte_pkg::ROOT_W-1:0] root_reg [0:SQN];
    qte_pkg::meta_t             sqm_reg  [0:SQN];

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0]  <= qte_pkg::RAD_W'(a4_reg * b4_reg);
            root_reg[0] <= '0;
            sqm_reg[0]  <= meta4_reg;
        end
    end

    for (genvar k = 0; k < SQN; k++) begin : g_sqrt
        localparam int BI = SQN - 1 - k;
        logic [qte_pkg::RAD_W:0] trial;
        logic                    take;
        assign trial = ((qte_pkg::RAD_W+1)'(root_reg[k]) << (BI + 1))
                     + ((qte_pkg::RAD_W+1)'(1) << (2 * BI));
        assign take  = ((qte_pkg::RAD_W+1)'(rem_reg[k]) >= trial);
        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k+1]  <= take ? qte_pkg::RAD_W'((qte_pkg::RAD_W+1)'(rem_reg[k]) - trial)
                                      : rem_reg[k];
                root_reg[k+1] <= take ? (root_reg[k] | (qte_pkg::ROOT_W'(1) << BI))
                                      : root_reg[k];
                sqm_reg[k+1]  <= sqm_reg[k];
            end
        end
    end

    // three cordics side by side
    qte_pkg::meta_t sm;
    assign sm = sqm_reg[SQN];

    logic [qte_pkg::ZOUT_W-1:0] roll_a, yaw_a, pitch_a;

    qte_atan #(.ITER(NI)) u_roll (
        .aclk (aclk), .en (en), .ay (sm.rs_mag), .ax (sm.rc_mag), .angle (roll_a)
    );
    qte_atan #(.ITER(NI)) u_yaw (
        .aclk (aclk), .en (en), .ay (sm.ys_mag), .ax (sm.yc_mag), .angle (yaw_a)
    );
    qte_atan #(.ITER(NI)) u_pitch (
        .aclk  (aclk),
        .en    (en),
        .ay    (MW'(sm.pm)),
        .ax    (MW'(root_reg[SQN])),
        .angle (pitch_a)
    );

    // sign flags travel beside the cordics
    qte_pkg::flags_t fl_reg [0:ATL-1];
    always_ff @(posedge aclk) begin
        if (en) begin
            fl_reg[0] <= '{rs_neg: sm.rs_neg, rc_neg: sm.rc_neg, ys_neg: sm.ys_neg,
                           yc_neg: sm.yc_neg, p_neg: sm.p_neg, p_clamp: sm.p_clamp,
                           invalid: sm.invalid};
            for (int i = 1; i < ATL; i++) fl_reg[i] <= fl_reg[i-1];
        end
    end

    // quadrant, rounding to 1/128 degree with ties away from zero, limit, sign
    function automatic logic [15:0] finish(input logic [qte_pkg::ZOUT_W:0] a,
                                           input logic neg, input logic [15:0] limit);
        logic [24:0] s;
        logic [15:0] r;
        s = 25'(a) + 25'd256;
        r = 16'(s >> 9);
        if (r > limit) r = limit;
        return neg ? -r : r;
    endfunction

    qte_pkg::flags_t fo;
    logic [qte_pkg::ZOUT_W:0] roll_q, yaw_q;
    logic [15:0] roll_next, yaw_next, pitch16;
    logic [14:0] pitch_next;

    assign fo = fl_reg[ATL-1];

    always_comb begin
        roll_q = fo.rc_neg ? qte_pkg::DEG180 - 24'(roll_a) : 24'(roll_a);
        yaw_q  = fo.yc_neg ? qte_pkg::DEG180 - 24'(yaw_a) : 24'(yaw_a);
        roll_next = finish(roll_q, fo.rs_neg, qte_pkg::ROLL_LIMIT);
        yaw_next  = finish(yaw_q, fo.ys_neg, qte_pkg::ROLL_LIMIT);
        if (fo.p_clamp) begin
            pitch16 = fo.p_neg ? -qte_pkg::PITCH_LIMIT : qte_pkg::PITCH_LIMIT;
        end else begin
            pitch16 = finish(24'(pitch_a), fo.p_neg, qte_pkg::PITCH_LIMIT);
        end
        pitch_next = pitch16[14:0];
        if (fo.invalid) begin
            roll_next  = '0;
            yaw_next   = '0;
            pitch_next = '0;
        end
    end

    // output register
    logic [15:0] roll_reg, yaw_reg;
    logic [14:0] pitch_reg;
    logic        inv_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            roll_reg  <= roll_next;
            pitch_reg <= pitch_next;
            yaw_reg   <= yaw_next;
            inv_reg   <= fo.invalid;
        end
    end

    assign m_tvalid = valid_reg[LAT-1];
    assign m_tdata  = {1'b0, yaw_reg, pitch_reg, roll_reg};
    assign m_tuser  = inv_reg;

    // zero quaternion gives zero angles
    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("invalid result with nonzero angles");

    // a held result stays put
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed under stall");

    // pitch stays within +/-90 degrees
    a_pitch_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[30:16]) <= 15'sd11520)
                  && ($signed(m_tdata[30:16]) >= -15'sd11520))
        else $error("pitch out of range");

    // input is refused only while a result is held
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input refused without stall");

endmodule
